@@ hdl/pcf_pkg.sv @@
// Package for the pixel colour filter: pixel payload structs, filter mode codes
// and the fixed weights and limits of the four filters.
// No dependencies.
package pcf_pkg;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pcf_pix_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } pcf_pix_out_t;

  typedef enum logic [1:0] {
    MODE_GRAY  = 2'd0,
    MODE_SEPIA = 2'd1,
    MODE_BOOST = 2'd2,
    MODE_BLUE  = 2'd3
  } pcf_mode_t;

  localparam int SepW = 19;

  localparam logic [SepW-1:0] SEP_RED_R   = 19'd393;
  localparam logic [SepW-1:0] SEP_RED_G   = 19'd769;
  localparam logic [SepW-1:0] SEP_RED_B   = 19'd189;
  localparam logic [SepW-1:0] SEP_GREEN_R = 19'd349;
  localparam logic [SepW-1:0] SEP_GREEN_G = 19'd686;
  localparam logic [SepW-1:0] SEP_GREEN_B = 19'd168;
  localparam logic [SepW-1:0] SEP_BLUE_R  = 19'd272;
  localparam logic [SepW-1:0] SEP_BLUE_G  = 19'd534;
  localparam logic [SepW-1:0] SEP_BLUE_B  = 19'd131;

  // floor(x/1000) = (x * 536871) >> 29, exact for x < 2^19
  localparam logic [19:0] DIV1000_MUL   = 20'd536871;
  localparam int          DIV1000_SHIFT = 29;
  // floor(x/3) = (x * 683) >> 11, exact for x < 2^10
  localparam logic [9:0]  DIV3_MUL      = 10'd683;
  localparam int          DIV3_SHIFT    = 11;

  localparam logic [7:0] BOOST_LIMIT  = 8'd235;
  localparam logic [7:0] BOOST_AMOUNT = 8'd20;
  localparam logic [7:0] BLUE_LIMIT   = 8'd205;
  localparam logic [7:0] BLUE_AMOUNT  = 8'd50;
  localparam logic [7:0] CHAN_MAX     = 8'd255;

endpackage

@@ hdl/pcf_filter.sv @@
// Combinational pixel filter: grayscale, sepia, dominant channel boost and
// blue boost on one registered pixel. Depends on pcf_pkg.
module pcf_filter
  import pcf_pkg::*;
(
  input  pcf_mode_t    mode,
  input  pcf_pix_in_t  pix_in,
  output pcf_pix_out_t pix_out
);

  function automatic logic [7:0] sep_scale(input logic [SepW-1:0] sum);
    logic [SepW+19:0] prod;
    logic [SepW+19-DIV1000_SHIFT:0] q;
    prod = {20'd0, sum} * {{SepW{1'b0}}, DIV1000_MUL};
    q = prod[SepW+19:DIV1000_SHIFT];
    return (q > {{(SepW+19-DIV1000_SHIFT-7){1'b0}}, CHAN_MAX}) ? CHAN_MAX : q[7:0];
  endfunction

  logic [SepW-1:0] r_w, g_w, b_w;
  logic [SepW-1:0] sep_r_sum, sep_g_sum, sep_b_sum;
  logic [9:0]      gray_sum;
  logic [19:0]     gray_prod;
  logic [7:0]      gray_avg;

  assign r_w = {{(SepW-8){1'b0}}, pix_in.red_in};
  assign g_w = {{(SepW-8){1'b0}}, pix_in.green_in};
  assign b_w = {{(SepW-8){1'b0}}, pix_in.blue_in};

  assign sep_r_sum = SEP_RED_R * r_w + SEP_RED_G * g_w + SEP_RED_B * b_w;
  assign sep_g_sum = SEP_GREEN_R * r_w + SEP_GREEN_G * g_w + SEP_GREEN_B * b_w;
  assign sep_b_sum = SEP_BLUE_R * r_w + SEP_BLUE_G * g_w + SEP_BLUE_B * b_w;

  assign gray_sum  = {2'b00, pix_in.blue_in} + {2'b00, pix_in.green_in}
                   + {2'b00, pix_in.red_in};
  assign gray_prod = {10'd0, gray_sum} * {10'd0, DIV3_MUL};
  assign gray_avg  = gray_prod[DIV3_SHIFT+7:DIV3_SHIFT];

  always_comb begin
    logic [7:0] r, g, b;
    logic       gate;
    r = pix_in.red_in;
    g = pix_in.green_in;
    b = pix_in.blue_in;
    gate = (r <= BOOST_LIMIT) && (b < BOOST_LIMIT) && (g < BOOST_LIMIT);
    pix_out.red_out   = r;
    pix_out.green_out = g;
    pix_out.blue_out  = b;
    case (mode)
      MODE_GRAY: begin
        pix_out.red_out   = gray_avg;
        pix_out.green_out = gray_avg;
        pix_out.blue_out  = gray_avg;
      end
      MODE_SEPIA: begin
        pix_out.red_out   = sep_scale(sep_r_sum);
        pix_out.green_out = sep_scale(sep_g_sum);
        pix_out.blue_out  = sep_scale(sep_b_sum);
      end
      MODE_BOOST: begin
        if (gate && b > r && b > g) pix_out.blue_out  = b + BOOST_AMOUNT;
        if (gate && r > b && r > g) pix_out.red_out   = r + BOOST_AMOUNT;
        if (gate && g > b && g > r) pix_out.green_out = g + BOOST_AMOUNT;
      end
      MODE_BLUE: begin
        pix_out.blue_out = (b < BLUE_LIMIT) ? b + BLUE_AMOUNT : CHAN_MAX;
      end
      default: begin
        pix_out.blue_out = b;
      end
    endcase
  end

endmodule

@@ hdl/pixel_color_filter_core.sv @@
// Pixel colour filter top level: input register, filter logic, result register.
// Depends on pcf_pkg and pcf_filter.
//
// Usage:
//   Input channel in_valid / in_stall / in_pixel carries one pixel (blue,
//   green, red bytes). Result channel out_valid / out_stall / out_pixel
//   carries the filtered pixel. A transfer takes place on a rising edge with
//   valid high and stall low.
//   cfg_we / cfg_wdata write the two-bit filter mode (0 grayscale, 1 sepia,
//   2 dominant channel boost, 3 blue boost); write only while no pixel is
//   in flight.
//   Path: an accepted pixel is held in the input register, then filtered
//   into the result register, which drives out_valid and out_pixel. Throughput:
//   one pixel per clock while out_stall is low; the filter is a single pass
//   of logic between the input register and the result register.
//   Stall: when out_stall holds a waiting result, the input register keeps
//   its pixel and in_stall rises once it is full; nothing is dropped.
//   Reset (rst_n low, synchronous) empties both registers and sets the mode
//   to grayscale.
module pixel_color_filter_core
  import pcf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  pcf_pix_in_t  in_pixel,
  output logic         out_valid,
  input  logic         out_stall,
  output pcf_pix_out_t out_pixel,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata
);

  pcf_mode_t    mode_r;
  logic         s1_valid_r, s1_valid_nxt;
  pcf_pix_in_t  s1_pix_r;
  logic         out_valid_r, out_valid_nxt;
  pcf_pix_out_t out_pixel_r;
  pcf_pix_out_t filt_pix;
  logic         out_adv;
  logic         in_take;

  pcf_filter u_filter (
    .mode    (mode_r),
    .pix_in  (s1_pix_r),
    .pix_out (filt_pix)
  );

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !out_adv);
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GRAY;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= pcf_mode_t'(cfg_wdata);
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_pix_r <= in_pixel;
    if (out_adv && s1_valid_r) out_pixel_r <= filt_pix;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("registered pixel did not reach the result register");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && $stable(s1_pix_r)))
    else $error("input register lost its pixel under stall");

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv && mode_r == MODE_GRAY) |=>
      (out_pixel_r.red_out == out_pixel_r.green_out &&
       out_pixel_r.green_out == out_pixel_r.blue_out))
    else $error("grayscale channels differ");

  a_blue_keeps_rg: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv && mode_r == MODE_BLUE) |=>
      (out_pixel_r.green_out == $past(s1_pix_r.green_in) &&
       out_pixel_r.red_out == $past(s1_pix_r.red_in)))
    else $error("blue boost altered red or green");
`endif

endmodule
